@@ sv/pba_pkg.sv @@
package pba_pkg;

  localparam int PAGES      = 4096;
  localparam int ZONES      = 4;
  localparam int ZONE_LIMIT = 4;
  localparam int NUM_REGS   = 4;

  localparam int PAGE_W     = $clog2(PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int WORD_PAGES = 8;
  localparam int BIT_W      = $clog2(WORD_PAGES);
  localparam int WORDS      = PAGES / WORD_PAGES;
  localparam int WADDR_W    = $clog2(WORDS);
  localparam int MAP_W      = 2 * WORD_PAGES;
  localparam int ZIDX_W     = $clog2(ZONES);
  localparam int RUN_W      = CNT_W + ZIDX_W;
  localparam int ZSEL_W     = 3;
  localparam int STS_W      = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_W      = 13;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DMA    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RES    = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0] KERNEL_RESET = '0;
  localparam logic [CFG_W-1:0] BOUND_RESET  = CFG_W'(PAGES);

  typedef logic [STS_W-1:0] status_t;
  localparam status_t STS_OK         = 3'd0;
  localparam status_t STS_BAD_ZONE   = 3'd1;
  localparam status_t STS_TOO_FEW    = 3'd2;
  localparam status_t STS_NO_RUN     = 3'd3;
  localparam status_t STS_NOT_HEADER = 3'd4;
  localparam status_t STS_BAD_COUNT  = 3'd5;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ZSEL_W-1:0] zone_select;
    logic [CNT_W-1:0]  page_count;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] first_page;
    logic [CNT_W-1:0]  run_pages;
    logic [CNT_W-1:0]  zone_free_pages;
  } rsp_t;

  typedef struct packed {
    logic [ZONES-1:0][CNT_W-1:0] lo;
    logic [ZONES-1:0][CNT_W-1:0] hi;
  } zone_map_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FRD,
    S_FCHK,
    S_FCLR,
    S_WGAP,
    S_WALK,
    S_FIN
  } state_t;

endpackage

@@ sv/page_bitmap_allocator_core.sv @@
// One request at a time; the map RAM is read one 8-page word per cycle.
// A bad count, bad zone or too few free pages goes straight to the result; a
// free reads the header word and ends there for a non-header page. An allocate
// searches from the zone pointer to the zone end, then wraps from the zone start,
// then marks the run; a free clears the run, then may walk the pointer back.
// Reset and every register write start a clearing pass over the whole map.
module page_bitmap_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  pba_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output pba_pkg::rsp_t                 rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pba_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = pba_pkg::CNT_W;
  localparam int WW = pba_pkg::WADDR_W;
  localparam int BW = pba_pkg::BIT_W;
  localparam int WP = pba_pkg::WORD_PAGES;

  pba_pkg::state_t    state, state_next;
  pba_pkg::zone_map_t zm;
  pba_pkg::req_t      op;
  pba_pkg::rsp_t      res;

  logic [pba_pkg::ZIDX_W-1:0]  zi;
  logic [CW-1:0] lo_r, hi_r, sptr, s_start, s_end, run, at_r, len_r, walk_cur;
  logic          pass2, pend;
  logic [WW-1:0] rd_word, pend_word, end_word;
  logic [pba_pkg::ZONES-1:0][CW-1:0] ptr, freec;

  logic                        map_we;
  logic [WW-1:0]               map_waddr;
  logic [pba_pkg::MAP_W-1:0]   map_wdata, map_q;
  logic                        run_we;
  logic [pba_pkg::RUN_W-1:0]   run_wdata, run_q;

  logic acc, cfg_hit, imm_err, hdr_ok, bad_zone;
  logic [pba_pkg::ZIDX_W-1:0] rz, fz;
  logic [CW-1:0] rlen;

  logic          scan_f, scan_last, walk_stop;
  logic [CW-1:0] scan_r, scan_at, walk_c;
  logic [WP-1:0] used_q, hdr_q, mark_used, mark_hdr, clr_used, clr_hdr;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (int'(cfg_index) < pba_pkg::NUM_REGS);
  assign req_stall = (state != pba_pkg::S_IDLE);
  assign acc       = req_valid && !req_stall;

  assign used_q = map_q[WP-1:0];
  assign hdr_q  = map_q[pba_pkg::MAP_W-1:WP];

  pba_zones u_zones (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .zm        (zm)
  );

  pba_ram #(.WIDTH(pba_pkg::MAP_W), .DEPTH(pba_pkg::WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (rd_word),
    .rdata (map_q)
  );

  pba_ram #(.WIDTH(pba_pkg::RUN_W), .DEPTH(pba_pkg::PAGES)) u_run (
    .clk   (clk),
    .we    (run_we),
    .waddr (at_r[pba_pkg::PAGE_W-1:0]),
    .wdata (run_wdata),
    .raddr (op.page_index),
    .rdata (run_q)
  );

  assign run_we    = (state == pba_pkg::S_MARK);
  assign run_wdata = {op.page_count, zi};

  // request checks at accept
  assign rz       = req.zone_select[pba_pkg::ZIDX_W-1:0];
  assign bad_zone = (int'(req.zone_select) >= pba_pkg::ZONE_LIMIT) ||
                    (int'(req.zone_select) >= pba_pkg::ZONES);
  assign imm_err  = (req.page_count == '0) || bad_zone || (freec[rz] < req.page_count);

  // header lookup on a free
  assign hdr_ok = ({1'b0, op.page_index} < CW'(pba_pkg::PAGES)) &&
                  hdr_q[op.page_index[BW-1:0]];
  assign rlen   = run_q[pba_pkg::RUN_W-1:pba_pkg::ZIDX_W];
  assign fz     = (int'(run_q[pba_pkg::ZIDX_W-1:0]) >= pba_pkg::ZONES) ? '0 :
                  run_q[pba_pkg::ZIDX_W-1:0];

  // search step over one word
  always_comb begin
    logic [CW-1:0] pg;
    scan_r  = run;
    scan_f  = 1'b0;
    scan_at = '0;
    for (int b = 0; b < WP; b++) begin
      pg = {1'b0, pend_word, BW'(b)};
      if (!scan_f && pg >= s_start && pg <= s_end) begin
        if (!used_q[b]) begin
          scan_r = scan_r + CW'(1);
          if (scan_r == op.page_count) begin
            scan_f  = 1'b1;
            scan_at = pg + CW'(1) - op.page_count;
          end
        end else begin
          scan_r = '0;
        end
      end
    end
    scan_last = (pend_word == s_end[pba_pkg::PAGE_W-1:BW]);
  end

  // word updates for marking and clearing a run
  always_comb begin
    logic [CW:0] pg;
    for (int b = 0; b < WP; b++) begin
      pg = {2'b00, pend_word, BW'(b)};
      mark_used[b] = used_q[b];
      mark_hdr[b]  = hdr_q[b];
      clr_used[b]  = used_q[b];
      clr_hdr[b]   = hdr_q[b];
      if (pg >= {1'b0, at_r} && pg < ({1'b0, at_r} + {1'b0, op.page_count})) begin
        mark_used[b] = 1'b1;
        mark_hdr[b]  = 1'b0;
      end
      if (pg == {1'b0, at_r}) mark_hdr[b] = 1'b1;
      if (pg >= {2'b00, op.page_index} &&
          pg < ({2'b00, op.page_index} + {1'b0, len_r})) begin
        clr_used[b] = 1'b0;
      end
      if (pg == {2'b00, op.page_index}) clr_hdr[b] = 1'b0;
    end
  end

  // pointer pull-back over one word, highest page first
  always_comb begin
    logic [CW-1:0] pg;
    walk_c    = walk_cur;
    walk_stop = 1'b0;
    for (int b = WP - 1; b >= 0; b--) begin
      pg = {1'b0, pend_word, BW'(b)};
      if (!walk_stop && (pg + CW'(1)) == walk_c) begin
        if (pg >= lo_r && !used_q[b]) walk_c = pg;
        else walk_stop = 1'b1;
      end
    end
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = pend_word;
    map_wdata = map_q;
    unique case (state)
      pba_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = rd_word;
        map_wdata = '0;
      end
      pba_pkg::S_MARK: begin
        map_we    = pend;
        map_wdata = {mark_hdr, mark_used};
      end
      pba_pkg::S_FCLR: begin
        map_we    = pend;
        map_wdata = {clr_hdr, clr_used};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= pba_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pba_pkg::S_CLEAR:
        if (rd_word == WW'(pba_pkg::WORDS - 1)) state_next = pba_pkg::S_IDLE;
      pba_pkg::S_IDLE:
        if (acc) begin
          if (req.req_type == pba_pkg::REQ_FREE) state_next = pba_pkg::S_FRD;
          else if (imm_err) state_next = pba_pkg::S_FIN;
          else state_next = pba_pkg::S_SCAN;
        end
      pba_pkg::S_SCAN:
        if (pend) begin
          if (scan_f) state_next = pba_pkg::S_MARK;
          else if (scan_last && pass2) state_next = pba_pkg::S_FIN;
        end
      pba_pkg::S_MARK:
        if (pend && pend_word == end_word) state_next = pba_pkg::S_FIN;
      pba_pkg::S_FRD:  state_next = pba_pkg::S_FCHK;
      pba_pkg::S_FCHK: state_next = hdr_ok ? pba_pkg::S_FCLR : pba_pkg::S_FIN;
      pba_pkg::S_FCLR:
        if (pend && pend_word == end_word) state_next = pba_pkg::S_WGAP;
      pba_pkg::S_WGAP:
        state_next = (walk_cur > lo_r) ? pba_pkg::S_WALK : pba_pkg::S_FIN;
      pba_pkg::S_WALK:
        if (pend && (walk_stop || walk_c == lo_r)) state_next = pba_pkg::S_FIN;
      pba_pkg::S_FIN:
        if (!rsp_valid || !rsp_stall) state_next = pba_pkg::S_IDLE;
      default: state_next = pba_pkg::S_CLEAR;
    endcase
    if (cfg_hit) state_next = pba_pkg::S_CLEAR;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == pba_pkg::S_FIN && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (state == pba_pkg::S_FIN && (!rsp_valid || !rsp_stall)) rsp <= res;
  end

  always_ff @(posedge clk) begin
    logic [CW-1:0] p0;
    logic [CW:0]   sum;
    logic [CW-1:0] size;
    if (rst) begin
      pend    <= 1'b0;
      rd_word <= '0;
    end else begin
      unique case (state)
        pba_pkg::S_CLEAR: begin
          rd_word <= rd_word + WW'(1);
          pend    <= 1'b0;
          for (int z = 0; z < pba_pkg::ZONES; z++) begin
            ptr[z]   <= zm.lo[z];
            freec[z] <= zm.hi[z] - zm.lo[z];
          end
        end
        pba_pkg::S_IDLE: begin
          pend <= 1'b0;
          if (acc) begin
            op <= req;
            zi <= rz;
            if (req.req_type == pba_pkg::REQ_FREE) begin
              rd_word <= req.page_index[pba_pkg::PAGE_W-1:BW];
            end else if (req.page_count == '0) begin
              res <= '{pba_pkg::STS_BAD_COUNT, '0, '0, '0};
            end else if (bad_zone) begin
              res <= '{pba_pkg::STS_BAD_ZONE, '0, '0, '0};
            end else if (freec[rz] < req.page_count) begin
              res <= '{pba_pkg::STS_TOO_FEW, '0, '0, freec[rz]};
            end else begin
              p0 = ptr[rz];
              if (p0 < zm.lo[rz] || p0 >= zm.hi[rz]) p0 = zm.lo[rz];
              lo_r    <= zm.lo[rz];
              hi_r    <= zm.hi[rz];
              sptr    <= p0;
              s_start <= p0;
              s_end   <= zm.hi[rz] - CW'(1);
              pass2   <= 1'b0;
              run     <= '0;
              rd_word <= p0[pba_pkg::PAGE_W-1:BW];
            end
          end
        end
        pba_pkg::S_SCAN: begin
          rd_word   <= rd_word + WW'(1);
          pend      <= 1'b1;
          pend_word <= rd_word;
          if (pend) begin
            run <= scan_r;
            if (scan_f) begin
              at_r     <= scan_at;
              rd_word  <= scan_at[pba_pkg::PAGE_W-1:BW];
              end_word <= WW'((scan_at + op.page_count - CW'(1)) >> BW);
              pend     <= 1'b0;
            end else if (scan_last) begin
              if (!pass2) begin
                // wrap: second pass from zone start up to the pointer
                pass2   <= 1'b1;
                s_start <= lo_r;
                s_end   <= sptr;
                run     <= '0;
                rd_word <= lo_r[pba_pkg::PAGE_W-1:BW];
                pend    <= 1'b0;
              end else begin
                res <= '{pba_pkg::STS_NO_RUN, '0, '0, freec[zi]};
              end
            end
          end
        end
        pba_pkg::S_MARK: begin
          rd_word   <= rd_word + WW'(1);
          pend      <= 1'b1;
          pend_word <= rd_word;
          if (pend && pend_word == end_word) begin
            pend      <= 1'b0;
            ptr[zi]   <= ((at_r + op.page_count) >= hi_r) ? lo_r : at_r + op.page_count;
            freec[zi] <= freec[zi] - op.page_count;
            res <= '{pba_pkg::STS_OK, at_r[pba_pkg::PAGE_W-1:0], op.page_count,
                     freec[zi] - op.page_count};
          end
        end
        pba_pkg::S_FRD: begin
          pend <= 1'b0;
        end
        pba_pkg::S_FCHK: begin
          pend <= 1'b0;
          if (!hdr_ok) begin
            res <= '{pba_pkg::STS_NOT_HEADER, op.page_index, '0, '0};
          end else begin
            sum  = {1'b0, freec[fz]} + {1'b0, rlen};
            size = zm.hi[fz] - zm.lo[fz];
            if (sum > {1'b0, size}) sum = {1'b0, size};
            zi        <= fz;
            lo_r      <= zm.lo[fz];
            len_r     <= rlen;
            freec[fz] <= sum[CW-1:0];
            walk_cur  <= (ptr[fz] > zm.hi[fz]) ? zm.hi[fz] : ptr[fz];
            end_word  <= WW'(({1'b0, op.page_index} + rlen - CW'(1)) >> BW);
            res <= '{pba_pkg::STS_OK, op.page_index, rlen, sum[CW-1:0]};
          end
        end
        pba_pkg::S_FCLR: begin
          rd_word   <= rd_word + WW'(1);
          pend      <= 1'b1;
          pend_word <= rd_word;
          if (pend && pend_word == end_word) pend <= 1'b0;
        end
        pba_pkg::S_WGAP: begin
          // an idle state so the walk reads the cleared words
          pend <= 1'b0;
          if (walk_cur > lo_r) begin
            rd_word <= WW'((walk_cur - CW'(1)) >> BW);
          end else begin
            ptr[zi] <= walk_cur;
          end
        end
        pba_pkg::S_WALK: begin
          rd_word   <= rd_word - WW'(1);
          pend      <= 1'b1;
          pend_word <= rd_word;
          if (pend) begin
            walk_cur <= walk_c;
            if (walk_stop || walk_c == lo_r) begin
              ptr[zi] <= walk_c;
              pend    <= 1'b0;
            end
          end
        end
        pba_pkg::S_FIN: begin
          pend <= 1'b0;
        end
        default: pend <= 1'b0;
      endcase
      if (cfg_hit) begin
        rd_word <= '0;
        pend    <= 1'b0;
      end
    end
  end

endmodule

@@ sv/pba_ram.sv @@
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pba_zones.sv @@
module pba_zones (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [pba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pba_pkg::CFG_W-1:0]      cfg_data,
  output pba_pkg::zone_map_t             zm
);

  logic [pba_pkg::CFG_W-1:0] regs [pba_pkg::NUM_REGS];
  logic [pba_pkg::CNT_W-1:0] bnd  [pba_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= pba_pkg::KERNEL_RESET;
      regs[1] <= pba_pkg::BOUND_RESET;
      regs[2] <= pba_pkg::BOUND_RESET;
      regs[3] <= pba_pkg::BOUND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pba_pkg::REG_KERNEL: regs[0] <= cfg_data;
        pba_pkg::REG_NORMAL: regs[1] <= cfg_data;
        pba_pkg::REG_DMA:    regs[2] <= cfg_data;
        pba_pkg::REG_RES:    regs[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // each boundary clipped to the map and kept at or above the one before
  always_comb begin
    logic [pba_pkg::CNT_W-1:0] b;
    logic [pba_pkg::CNT_W-1:0] floor_v;
    floor_v = '0;
    for (int i = 0; i < pba_pkg::NUM_REGS; i++) begin
      if (int'(regs[i]) > pba_pkg::PAGES) b = pba_pkg::CNT_W'(pba_pkg::PAGES);
      else b = pba_pkg::CNT_W'(regs[i]);
      if (b < floor_v) b = floor_v;
      bnd[i] = b;
      floor_v = b;
    end
    for (int z = 0; z < pba_pkg::ZONES; z++) begin
      if (z < 3) begin
        zm.lo[z] = bnd[z];
        zm.hi[z] = bnd[z+1];
      end else begin
        zm.lo[z] = bnd[3];
        zm.hi[z] = bnd[3];
      end
    end
  end

endmodule
